>>> hw/rtl/bmp24_stream_parser_macros.svh
// ---------------------------------------------------------------------------
// bmp24_stream_parser assertion macros
// Shared property forms for the parser's checks; clk and rst come from the
// module that uses them.
// ---------------------------------------------------------------------------
`ifndef BMP24_STREAM_PARSER_MACROS_SVH
`define BMP24_STREAM_PARSER_MACROS_SVH

// same-cycle implication
`define BMP24SP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BMP24SP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/bmp24sp_pkg.sv
// ---------------------------------------------------------------------------
// bmp24sp_pkg
// Types and constants shared by the 24-bit BMP stream parser.
// ---------------------------------------------------------------------------
package bmp24sp_pkg;

  localparam int MAX_DIM     = 4096;
  localparam int DIM_W       = 13;
  localparam int POS_W       = 12;
  localparam int OFF_W       = 6;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0]  SIG_B     = 8'h42;
  localparam logic [7:0]  SIG_M     = 8'h4D;
  localparam logic [31:0] INFO_SIZE = 32'd40;

  localparam logic [OFF_W-1:0] OFF_SIG0       = 6'd0;
  localparam logic [OFF_W-1:0] OFF_SIG1       = 6'd1;
  localparam logic [OFF_W-1:0] OFF_INFO_END   = 6'd17;
  localparam logic [OFF_W-1:0] OFF_WIDTH_END  = 6'd21;
  localparam logic [OFF_W-1:0] OFF_HEIGHT_END = 6'd25;
  localparam logic [OFF_W-1:0] OFF_HEADER_END = 6'd53;

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] ERR_SIGNATURE = 2'd0;
  localparam logic [1:0] ERR_INFO_SIZE = 2'd1;
  localparam logic [1:0] ERR_DIMENSION = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [1:0]       error_code;
    logic             last_pixel;
  } result_t;

endpackage

>>> hw/rtl/bmp24sp_front.sv
// ---------------------------------------------------------------------------
// bmp24sp_front
// Byte parser: checks and captures the header, assembles pixels, drops row
// padding, and produces at most one result per accepted beat.
// ---------------------------------------------------------------------------
`include "bmp24_stream_parser_macros.svh"

module bmp24sp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 first_byte,
  output logic                 push,
  output bmp24sp_pkg::result_t result
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_PIXELS = 2'd2;
  localparam logic [1:0] PH_STOP   = 2'd3;

  localparam int DW = bmp24sp_pkg::DIM_W;
  localparam int PW = bmp24sp_pkg::POS_W;
  localparam int OW = bmp24sp_pkg::OFF_W;

  logic [1:0]    phase,         phase_next;
  logic [OW-1:0] header_offset, header_offset_next;
  logic [31:0]   word_assembly, word_assembly_next;
  logic [DW-1:0] width_store,   width_store_next;
  logic [DW-1:0] height_store,  height_store_next;
  logic [PW-1:0] column_count,  column_count_next;
  logic [PW-1:0] row_count,     row_count_next;
  logic [1:0]    channel_count, channel_count_next;
  logic [1:0]    pad_count,     pad_count_next;
  logic [7:0]    blue_hold,     blue_hold_next;
  logic [7:0]    green_hold,    green_hold_next;

  logic [1:0]    phase_eff;
  logic [OW-1:0] off_eff;
  logic [31:0]   wa_shift;
  logic          err;
  logic [1:0]    err_code;
  logic [DW-1:0] col_inc;
  logic [DW-1:0] row_inc;
  logic          last;

  always_comb begin
    phase_eff = first_byte ? PH_HEADER : phase;
    off_eff   = first_byte ? '0 : header_offset;
    wa_shift  = {data_byte, (first_byte ? 24'd0 : word_assembly[31:8])};
    col_inc   = {1'b0, column_count} + 1'b1;
    row_inc   = {1'b0, row_count} + 1'b1;
    last      = (row_inc == height_store) && (col_inc == width_store);

    phase_next         = phase;
    header_offset_next = header_offset;
    word_assembly_next = word_assembly;
    width_store_next   = width_store;
    height_store_next  = height_store;
    column_count_next  = column_count;
    row_count_next     = row_count;
    channel_count_next = channel_count;
    pad_count_next     = pad_count;
    blue_hold_next     = blue_hold;
    green_hold_next    = green_hold;
    err                = 1'b0;
    err_code           = bmp24sp_pkg::ERR_SIGNATURE;
    push               = 1'b0;
    result             = '0;

    if (accept) begin
      if (first_byte) begin
        width_store_next   = '0;
        height_store_next  = '0;
        column_count_next  = '0;
        row_count_next     = '0;
        channel_count_next = '0;
        pad_count_next     = '0;
        blue_hold_next     = '0;
        green_hold_next    = '0;
      end
      unique case (phase_eff)
        PH_HEADER: begin
          phase_next         = PH_HEADER;
          word_assembly_next = wa_shift;
          header_offset_next = off_eff + 1'b1;
          priority if (off_eff == bmp24sp_pkg::OFF_SIG0) begin
            if (data_byte != bmp24sp_pkg::SIG_B) begin
              err      = 1'b1;
              err_code = bmp24sp_pkg::ERR_SIGNATURE;
            end
          end else if (off_eff == bmp24sp_pkg::OFF_SIG1) begin
            if (data_byte != bmp24sp_pkg::SIG_M) begin
              err      = 1'b1;
              err_code = bmp24sp_pkg::ERR_SIGNATURE;
            end
          end else if (off_eff == bmp24sp_pkg::OFF_INFO_END) begin
            if (wa_shift != bmp24sp_pkg::INFO_SIZE) begin
              err      = 1'b1;
              err_code = bmp24sp_pkg::ERR_INFO_SIZE;
            end
          end else if (off_eff == bmp24sp_pkg::OFF_WIDTH_END) begin
            if (wa_shift > 32'(bmp24sp_pkg::MAX_DIM)) begin
              err      = 1'b1;
              err_code = bmp24sp_pkg::ERR_DIMENSION;
            end else begin
              width_store_next = wa_shift[DW-1:0];
            end
          end else if (off_eff == bmp24sp_pkg::OFF_HEIGHT_END) begin
            if (wa_shift > 32'(bmp24sp_pkg::MAX_DIM)) begin
              err      = 1'b1;
              err_code = bmp24sp_pkg::ERR_DIMENSION;
            end else begin
              height_store_next = wa_shift[DW-1:0];
            end
          end else if (off_eff == bmp24sp_pkg::OFF_HEADER_END) begin
            push                = 1'b1;
            result.kind         = bmp24sp_pkg::KIND_HEADER;
            result.image_width  = width_store;
            result.image_height = height_store;
            result.last_pixel   = (width_store == '0) || (height_store == '0);
            column_count_next   = '0;
            row_count_next      = '0;
            channel_count_next  = '0;
            pad_count_next      = '0;
            phase_next          = result.last_pixel ? PH_STOP : PH_PIXELS;
          end else begin
          end
          if (err) begin
            push              = 1'b1;
            result.kind       = bmp24sp_pkg::KIND_ERROR;
            result.error_code = err_code;
            phase_next        = PH_STOP;
          end
        end
        PH_PIXELS: begin
          priority if (pad_count != 2'd0) begin
            pad_count_next = pad_count - 1'b1;
          end else if (channel_count == 2'd0) begin
            blue_hold_next     = data_byte;
            channel_count_next = 2'd1;
          end else if (channel_count == 2'd1) begin
            green_hold_next    = data_byte;
            channel_count_next = 2'd2;
          end else begin
            channel_count_next = 2'd0;
            push               = 1'b1;
            result.kind        = bmp24sp_pkg::KIND_PIXEL;
            result.red         = data_byte;
            result.green       = green_hold;
            result.blue        = blue_hold;
            result.column      = column_count;
            result.row         = row_count;
            result.last_pixel  = last;
            priority if (last) begin
              phase_next = PH_STOP;
            end else if (col_inc >= width_store) begin
              column_count_next = '0;
              row_count_next    = row_inc[PW-1:0];
              pad_count_next    = width_store[1:0];
            end else begin
              column_count_next = col_inc[PW-1:0];
            end
          end
        end
        PH_IDLE, PH_STOP: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      header_offset <= '0;
      word_assembly <= '0;
      width_store   <= '0;
      height_store  <= '0;
      column_count  <= '0;
      row_count     <= '0;
      channel_count <= '0;
      pad_count     <= '0;
    end else begin
      phase         <= phase_next;
      header_offset <= header_offset_next;
      word_assembly <= word_assembly_next;
      width_store   <= width_store_next;
      height_store  <= height_store_next;
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      channel_count <= channel_count_next;
      pad_count     <= pad_count_next;
    end
  end

  always_ff @(posedge clk) begin
    blue_hold  <= blue_hold_next;
    green_hold <= green_hold_next;
  end

  `BMP24SP_ASSERT_NOW(a_quiet_when_parked,
    accept && !first_byte && (phase == PH_IDLE || phase == PH_STOP), !push,
    "result produced while parser is parked")
  `BMP24SP_ASSERT_NOW(a_pixel_in_pixel_phase,
    push && (result.kind == bmp24sp_pkg::KIND_PIXEL),
    !first_byte && (phase == PH_PIXELS),
    "pixel result outside pixel phase")

endmodule

>>> hw/rtl/bmp24sp_queue.sv
// ---------------------------------------------------------------------------
// bmp24sp_queue
// Small result queue between the parser and the output stage.
// ---------------------------------------------------------------------------
`include "bmp24_stream_parser_macros.svh"

module bmp24sp_queue #(
  parameter int DEPTH = bmp24sp_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  bmp24sp_pkg::result_t push_data,
  output logic                 full,
  input  logic                 pop,
  output bmp24sp_pkg::result_t pop_data,
  output logic                 empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

  bmp24sp_pkg::result_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `BMP24SP_ASSERT_NOW(a_no_push_full, full, !push, "push into full queue")
  `BMP24SP_ASSERT_NOW(a_no_pop_empty, pop, !empty, "pop from empty queue")
  `BMP24SP_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1,
    "queue count did not advance on push")

endmodule

>>> hw/rtl/bmp24sp_back.sv
// ---------------------------------------------------------------------------
// bmp24sp_back
// Output stage: pulls results from the queue into the output register and
// holds each one until the downstream beat completes.
// ---------------------------------------------------------------------------
module bmp24sp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  bmp24sp_pkg::result_t q_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bmp24sp_pkg::result_t out_data
);

  assign pop = !q_empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= q_data;
    end
  end

endmodule

>>> hw/rtl/bmp24_stream_parser.sv
// ---------------------------------------------------------------------------
// bmp24_stream_parser: 24-bit uncompressed BMP byte-stream parser
// Throughput: one byte in and up to one result out per cycle, unless stalled.
// Path: a result goes through the result queue into the output register.
// The result queue (QUEUE_DEPTH entries) sets how long out_stall is absorbed.
// Reset: synchronous; parser idle until a byte with first_byte set arrives.
// ---------------------------------------------------------------------------
module bmp24_stream_parser #(
  parameter int QUEUE_DEPTH = bmp24sp_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     data_byte,
  input  logic                           first_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     kind,
  output logic [7:0]                     red,
  output logic [7:0]                     green,
  output logic [7:0]                     blue,
  output logic [bmp24sp_pkg::POS_W-1:0] column,
  output logic [bmp24sp_pkg::POS_W-1:0] row,
  output logic [bmp24sp_pkg::DIM_W-1:0] image_width,
  output logic [bmp24sp_pkg::DIM_W-1:0] image_height,
  output logic [1:0]                     error_code,
  output logic                           last_pixel
);

  logic                 accept;
  logic                 push;
  logic                 q_full;
  logic                 q_empty;
  logic                 pop;
  bmp24sp_pkg::result_t front_result;
  bmp24sp_pkg::result_t q_data;
  bmp24sp_pkg::result_t out_data;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  bmp24sp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .push       (push),
    .result     (front_result)
  );

  bmp24sp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_result),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  bmp24sp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign kind         = out_data.kind;
  assign red          = out_data.red;
  assign green        = out_data.green;
  assign blue         = out_data.blue;
  assign column       = out_data.column;
  assign row          = out_data.row;
  assign image_width  = out_data.image_width;
  assign image_height = out_data.image_height;
  assign error_code   = out_data.error_code;
  assign last_pixel   = out_data.last_pixel;

endmodule
